// ===== rtl/core/audio_volume_beat_tempo_detector_assert.svh =====
// Assertion macros of the beat detector RTL, used by avbt_back.
`ifndef AUDIO_VOLUME_BEAT_TEMPO_DETECTOR_ASSERT_SVH
`define AUDIO_VOLUME_BEAT_TEMPO_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define AVBT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define AVBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/avbt_pkg.sv =====
// Shared types and constants of the beat detector.
package avbt_pkg;

	localparam int SQ_W     = 44;
	localparam int CNT_W    = 13;
	localparam logic [17:0] PP_LIMIT = 18'd131072;
	localparam logic [15:0] BPM_NUM  = 16'd60000;

	localparam logic [1:0] REG_VOL_WEIGHT   = 2'd0;
	localparam logic [1:0] REG_ENERGY_RATIO = 2'd1;
	localparam logic [1:0] REG_COOLDOWN     = 2'd2;
	localparam logic [1:0] REG_LONG_WEIGHT  = 2'd3;

	typedef struct packed {
		logic signed [31:0] raw_word;
		logic               window_last;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  volume;
		logic        beat;
		logic [15:0] bpm;
	} out_item_t;

	typedef struct packed {
		logic [17:0]      pp;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] count;
		logic [31:0]      now_ms;
	} win_rec_t;

	typedef struct packed {
		logic [7:0]  volume_smooth_weight;
		logic [9:0]  energy_ratio;
		logic [15:0] cooldown_ms;
		logic [15:0] long_avg_weight;
	} cfg_t;

endpackage

// ===== rtl/core/avbt_fifo.sv =====
// Two-entry queue between the window front end and the back end.
module avbt_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	output logic  full,
	input  logic  rd,
	output item_t rdata,
	output logic  empty
);
	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end
endmodule

// ===== rtl/core/avbt_front.sv =====
// Per-sample window statistics: min, max, saturating sum of squares, count.
module avbt_front #(
	parameter int WINDOW_MAX = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  avbt_pkg::in_item_t sample,
	output logic               rec_push,
	output avbt_pkg::win_rec_t rec
);
	localparam int CW = $clog2(WINDOW_MAX + 1);

	logic signed [17:0] min_q, max_q, s, min_n, max_n;
	logic [43:0]        sq_q, sq_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic [17:0]        mag;
	logic [35:0]        sqr;
	logic [44:0]        sum;
	logic signed [18:0] diff;
	logic               close;

	always_comb begin
		s     = sample.raw_word[31:14];
		mag   = s[17] ? 18'(-s) : 18'(s);
		sqr   = 36'(mag) * 36'(mag);
		sum   = 45'(sq_q) + 45'(sqr);
		sq_n  = sum[44] ? {44{1'b1}} : sum[43:0];
		min_n = (s < min_q) ? s : min_q;
		max_n = (s > max_q) ? s : max_q;
		cnt_n = cnt_q + CW'(1);
		close = sample.window_last || (cnt_n == CW'(WINDOW_MAX));
		diff  = 19'(max_n) - 19'(min_n);
		rec.pp     = (diff > 19'(avbt_pkg::PP_LIMIT)) ? avbt_pkg::PP_LIMIT : diff[17:0];
		rec.sq     = sq_n;
		rec.count  = avbt_pkg::CNT_W'(cnt_n);
		rec.now_ms = sample.now_ms;
		rec_push   = accept && close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 18'sh1FFFF;
			max_q <= 18'sh20000;
			sq_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (close) begin
				min_q <= 18'sh1FFFF;
				max_q <= 18'sh20000;
				sq_q  <= '0;
				cnt_q <= '0;
			end else begin
				min_q <= min_n;
				max_q <= max_n;
				sq_q  <= sq_n;
				cnt_q <= cnt_n;
			end
		end
	end
endmodule

// ===== rtl/core/avbt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module avbt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [59:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [59:0] quotient
);
	logic [59:0] quo_q;
	logic [32:0] rem_q, r2;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic        ge;

	assign busy     = (cnt_q != 6'd0);
	assign done     = done_q;
	assign quotient = quo_q;

	always_comb begin
		r2 = {rem_q[31:0], quo_q[59]};
		ge = (r2 >= 33'(dvs_q));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? (r2 - 33'(dvs_q)) : r2;
			quo_q <= {quo_q[58:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (start) cnt_q <= 6'd60;
			else if (busy) cnt_q <= cnt_q - 6'd1;
		end
	end
endmodule

// ===== rtl/core/avbt_back.sv =====
// Window-end sequencer: volume EMA, energy, beat test, tempo, long average.
`include "audio_volume_beat_tempo_detector_assert.svh"
module avbt_back #(
	parameter int BEAT_HISTORY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  avbt_pkg::cfg_t      cfg,
	input  avbt_pkg::win_rec_t  rec,
	input  logic                rec_empty,
	output logic                rec_pop,
	output avbt_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);
	localparam int IW = (BEAT_HISTORY > 1) ? $clog2(BEAT_HISTORY) : 1;
	localparam int FW = $clog2(BEAT_HISTORY + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_VOL  = 10'b0000000010,
		S_DIVE = 10'b0000000100,
		S_MULR = 10'b0000001000,
		S_RING = 10'b0000010000,
		S_DIVS = 10'b0000100000,
		S_DIVT = 10'b0001000000,
		S_EMA  = 10'b0010000000,
		S_OUT  = 10'b0100000000,
		S_CMP  = 10'b1000000000
	} state_t;

	state_t             state_q;
	avbt_pkg::win_rec_t rec_q;
	avbt_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic [15:0]        vavg_q;
	logic [50:0]        energy_q, long_q;
	logic               primed_q, beat_q;
	logic [31:0]        last_beat_q;
	logic [31:0]        ring_q [BEAT_HISTORY];
	logic [IW-1:0]      idx_q;
	logic [FW-1:0]      fill_q;
	logic [15:0]        tempo_q;

	// shared 17x17 multiply-accumulate
	logic        mac_ema_q, mac_run_q, pv_q;
	logic [2:0]  step_q;
	logic [1:0]  kp_q;
	logic [33:0] prod_q;
	logic [67:0] acc_q;
	logic [50:0] mop;
	logic [16:0] mchunk, mfac;
	logic [1:0]  kcur;
	logic        mac_done;

	// divider
	logic        div_start, div_busy, div_done;
	logic [59:0] div_a, div_q;
	logic [31:0] div_b;

	logic [16:0] vol;
	logic [26:0] vsum;
	logic [FW:0] old_t;
	logic [IW-1:0] oldest;
	logic [31:0] span;

	always_comb begin
		kcur   = (step_q >= 3'd3) ? 2'(step_q - 3'd3) : step_q[1:0];
		mop    = (step_q < 3'd3) ? long_q : energy_q;
		case (kcur)
			2'd0:    mchunk = mop[16:0];
			2'd1:    mchunk = mop[33:17];
			default: mchunk = mop[50:34];
		endcase
		if (!mac_ema_q) mfac = 17'(cfg.energy_ratio);
		else if (step_q < 3'd3) mfac = 17'd65536 - 17'(cfg.long_avg_weight);
		else mfac = 17'(cfg.long_avg_weight);
		mac_done = mac_run_q && !pv_q && (step_q == (mac_ema_q ? 3'd6 : 3'd3));

		vol  = 17'((26'(rec_q.pp) * 26'd255) >> 9);
		vsum = 27'(vavg_q) * 27'(9'd256 - 9'(cfg.volume_smooth_weight))
			+ 27'(vol) * 27'(cfg.volume_smooth_weight) + 27'd128;

		old_t = (FW+1)'(idx_q) + (FW+1)'(BEAT_HISTORY) - (FW+1)'(fill_q);
		if (old_t >= (FW+1)'(BEAT_HISTORY)) old_t = old_t - (FW+1)'(BEAT_HISTORY);
		oldest = old_t[IW-1:0];
		span   = rec_q.now_ms - ring_q[oldest];

		div_start = 1'b0;
		div_a     = {rec_q.sq, 16'd0};
		div_b     = 32'(rec_q.count);
		case (state_q)
			S_VOL: div_start = 1'b1;
			S_RING: begin
				div_a     = 60'(span);
				div_b     = 32'(fill_q - FW'(1));
				div_start = (fill_q >= FW'(2)) && (span != 32'd0);
			end
			S_DIVS: begin
				div_a     = 60'(avbt_pkg::BPM_NUM);
				div_b     = div_q[31:0];
				div_start = div_done && (div_q[31:0] != 32'd0);
			end
			default: ;
		endcase
		rec_pop = (state_q == S_IDLE) && !rec_empty;
	end

	avbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign result = out_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (rec_pop) rec_q <= rec;
		if (state_q == S_MULR && mac_done && ({energy_q, 8'd0} > acc_q[58:0])
			&& acc_q[67:59] == 9'd0) begin
			ring_q[idx_q] <= rec_q.now_ms;
		end
		if (mac_run_q) begin
			prod_q <= 34'(mchunk) * 34'(mfac);
			kp_q   <= kcur;
		end
		if (state_q == S_OUT && !out_valid_q) begin
			out_q.volume <= 8'((17'(vavg_q) + 17'd128) >> 8);
			out_q.beat   <= beat_q;
			out_q.bpm    <= tempo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vavg_q      <= '0;
			energy_q    <= '0;
			long_q      <= '0;
			primed_q    <= 1'b0;
			beat_q      <= 1'b0;
			last_beat_q <= '0;
			idx_q       <= '0;
			fill_q      <= '0;
			tempo_q     <= '0;
			mac_ema_q   <= 1'b0;
			mac_run_q   <= 1'b0;
			pv_q        <= 1'b0;
			step_q      <= '0;
			acc_q       <= '0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;

			// MAC sequencing; the ratio-to-EMA hand-over is done in S_MULR
			if (mac_run_q && !(state_q == S_MULR && mac_done)) begin
				pv_q <= (step_q != (mac_ema_q ? 3'd6 : 3'd3));
				if (step_q != (mac_ema_q ? 3'd6 : 3'd3)) step_q <= step_q + 3'd1;
				if (pv_q) acc_q <= acc_q + (68'(prod_q) << (17 * kp_q));
				if (mac_done) mac_run_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (!rec_empty) state_q <= S_VOL;
				end
				S_VOL: begin
					vavg_q  <= vsum[23:8];
					beat_q  <= 1'b0;
					state_q <= S_DIVE;
				end
				S_DIVE: begin
					if (div_done) begin
						energy_q <= div_q[50:0];
						if (!primed_q) begin
							long_q   <= div_q[50:0];
							primed_q <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					mac_run_q <= 1'b1;
					pv_q      <= 1'b0;
					step_q    <= '0;
					if ((rec_q.now_ms - last_beat_q) >= 32'(cfg.cooldown_ms)
						&& long_q != '0) begin
						mac_ema_q <= 1'b0;
						acc_q     <= '0;
						state_q   <= S_MULR;
					end else begin
						mac_ema_q <= 1'b1;
						acc_q     <= 68'd32768;
						state_q   <= S_EMA;
					end
				end
				S_MULR: begin
					if (mac_done) begin
						mac_ema_q <= 1'b1;
						pv_q      <= 1'b0;
						step_q    <= '0;
						acc_q     <= 68'd32768;
						if (({energy_q, 8'd0} > acc_q[58:0]) && acc_q[67:59] == 9'd0) begin
							beat_q      <= 1'b1;
							last_beat_q <= rec_q.now_ms;
							idx_q       <= (idx_q == IW'(BEAT_HISTORY - 1)) ? '0 : idx_q + IW'(1);
							if (fill_q < FW'(BEAT_HISTORY)) fill_q <= fill_q + FW'(1);
							mac_run_q   <= 1'b0;
							state_q     <= S_RING;
						end else begin
							state_q <= S_EMA;
						end
					end
				end
				S_RING: begin
					if (div_start) begin
						state_q <= S_DIVS;
					end else begin
						mac_run_q <= 1'b1;
						state_q   <= S_EMA;
					end
				end
				S_DIVS: begin
					if (div_done) begin
						if (div_start) begin
							state_q <= S_DIVT;
						end else begin
							mac_run_q <= 1'b1;
							state_q   <= S_EMA;
						end
					end
				end
				S_DIVT: begin
					if (div_done) begin
						tempo_q   <= div_q[15:0];
						mac_run_q <= 1'b1;
						state_q   <= S_EMA;
					end
				end
				S_EMA: begin
					if (mac_done) begin
						long_q  <= acc_q[66:16];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`AVBT_ASSERT_NOW(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")
	`AVBT_ASSERT_NEXT(a_out_hold, state_q == S_OUT && out_valid_q && !pop, state_q == S_OUT, "result lost")
	`AVBT_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= FW'(BEAT_HISTORY), "beat ring overfilled")
	`AVBT_ASSERT_NOW(a_beat_primed, beat_q, primed_q, "beat before long average seeded")
endmodule

// ===== rtl/core/audio_volume_beat_tempo_detector.sv =====
// Top level of the audio volume, beat and tempo detector.
// Usage:
//  Input queue: drive sample and raise push; an item is taken on a clock edge
//  with push high and full low. One item is one microphone word plus the
//  window_last marker and the millisecond time stamp.
//  Result queue: while empty is low, result holds volume, beat and bpm of the
//  oldest finished window; pop with empty low takes it.
//  One result comes out per window: on window_last or when WINDOW_MAX samples
//  have been seen.
// Throughput: one item per cycle at the front end while full is low. Each window
//  end goes to a two-entry queue, worked off one window at a time by a back end
//  with a one-bit-per-cycle divider and a 17x17 multiply-accumulate. full rises
//  only while that queue is full.
// Reset: clears window statistics, averages, beat history, tempo and queues,
//  and loads the register defaults; no clearing pass is needed.
// Stall: a result not taken holds the back end after it has finished the
//  next window; the front end keeps accepting until the queue fills.
module audio_volume_beat_tempo_detector #(
	parameter int WINDOW_MAX   = 512,
	parameter int BEAT_HISTORY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  avbt_pkg::in_item_t  sample,
	input  logic                push,
	output logic                full,
	output avbt_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);
	avbt_pkg::cfg_t     cfg_q;
	avbt_pkg::win_rec_t rec_in, rec_out;
	logic               rec_push, rec_full, rec_empty, rec_pop, accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_smooth_weight <= 8'd77;
			cfg_q.energy_ratio         <= 10'd410;
			cfg_q.cooldown_ms          <= 16'd200;
			cfg_q.long_avg_weight      <= 16'd131;
		end else if (cfg_wen) begin
			case (cfg_index)
				avbt_pkg::REG_VOL_WEIGHT:   cfg_q.volume_smooth_weight <= cfg_data[7:0];
				avbt_pkg::REG_ENERGY_RATIO: cfg_q.energy_ratio         <= cfg_data[9:0];
				avbt_pkg::REG_COOLDOWN:     cfg_q.cooldown_ms          <= cfg_data;
				avbt_pkg::REG_LONG_WEIGHT:  cfg_q.long_avg_weight      <= cfg_data;
				default: ;
			endcase
		end
	end

	// conservative: hold input whenever the window queue is full
	assign full   = rec_full;
	assign accept = push && !rec_full;

	avbt_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (sample),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	avbt_fifo #(.item_t(avbt_pkg::win_rec_t)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rec_push),
		.wdata  (rec_in),
		.full   (rec_full),
		.rd     (rec_pop),
		.rdata  (rec_out),
		.empty  (rec_empty)
	);

	avbt_back #(.BEAT_HISTORY(BEAT_HISTORY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec       (rec_out),
		.rec_empty (rec_empty),
		.rec_pop   (rec_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);
endmodule

// ===== verif/avbt_checker.sv =====
// Checker for the beat detector: predicts each window result and compares it with the result port.
module avbt_checker #(
	parameter int WINDOW_MAX   = 512,
	parameter int BEAT_HISTORY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  avbt_pkg::in_item_t  sample,
	input  logic                push,
	input  logic                full,
	input  avbt_pkg::out_item_t result,
	input  logic                empty,
	input  logic                pop,
	output int                  failures,
	output int                  pending,
	output int                  windows_closed,
	output int                  beats_flagged
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = (BEAT_HISTORY > 1) ? $clog2(BEAT_HISTORY) : 1;
	localparam logic [43:0] SQ_MAX = '1;

	avbt_pkg::cfg_t      cfg;
	logic signed [17:0]  win_lo, win_hi;
	logic [43:0]         sq_acc;
	int unsigned         n_samples;
	logic [31:0]         vol_avg;
	logic [63:0]         long_energy;
	bit                  primed;
	logic [31:0]         last_beat_ms;
	logic [31:0]         beat_ms [BEAT_HISTORY];
	logic [IW-1:0]       ring_pos;
	logic [IW:0]         ring_fill;
	logic [15:0]         tempo_bpm;
	avbt_pkg::out_item_t due_results [$];

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	task automatic clear_window();
		win_lo    = 18'sd131071;
		win_hi    = -18'sd131072;
		sq_acc    = '0;
		n_samples = 0;
	endtask

	task automatic log_beat(input logic [31:0] now);
		logic [31:0] span, gap;
		int          oldest, newest;
		last_beat_ms = now;
		beat_ms[ring_pos] = now;
		ring_pos = IW'((ring_pos + 1) % BEAT_HISTORY);
		if (ring_fill < BEAT_HISTORY)
			ring_fill++;
		if (ring_fill >= 2) begin
			oldest = (ring_pos + BEAT_HISTORY - ring_fill) % BEAT_HISTORY;
			newest = (ring_pos + BEAT_HISTORY - 1) % BEAT_HISTORY;
			span = beat_ms[newest] - beat_ms[oldest];
			if (span > 0) begin
				gap = span / 32'(ring_fill - 1);
				if (gap > 0)
					tempo_bpm = 16'(32'd60000 / gap);
			end
		end
	endtask

	// One accepted item; queues a result when it closes the window.
	task automatic take_sample(input avbt_pkg::in_item_t it);
		logic signed [17:0]  s;
		int                  si;
		logic [35:0]         mag;
		logic [44:0]         acc;
		logic [31:0]         pp, vol, w;
		logic [63:0]         energy;
		logic [79:0]         blend;
		bit                  beat;
		avbt_pkg::out_item_t want;
		s   = it.raw_word[31:14];
		si  = s;
		mag = 36'((si < 0) ? -si : si);
		beat = 0;
		if (s < win_lo) win_lo = s;
		if (s > win_hi) win_hi = s;
		acc = 45'(sq_acc) + 45'(mag) * 45'(mag);
		sq_acc = (acc > 45'(SQ_MAX)) ? SQ_MAX : acc[43:0];
		n_samples++;
		if (!it.window_last && n_samples < WINDOW_MAX)
			return;

		pp = 32'(int'(win_hi) - int'(win_lo));
		if (pp > 32'd131072) pp = 32'd131072;
		vol = (pp * 32'd255) >> 9;
		w = 32'(cfg.volume_smooth_weight);
		vol_avg = (vol_avg * (32'd256 - w) + vol * w + 32'd128) >> 8;
		energy = (64'(sq_acc) << 16) / 64'(n_samples);

		if (!primed) begin
			long_energy = energy;
			primed = 1;
		end else begin
			if ((it.now_ms - last_beat_ms) >= 32'(cfg.cooldown_ms) && long_energy > 0 &&
				energy * 64'd256 > long_energy * 64'(cfg.energy_ratio)) begin
				beat = 1;
				log_beat(it.now_ms);
			end
			blend = 80'(long_energy) * (80'd65536 - 80'(cfg.long_avg_weight)) +
				80'(energy) * 80'(cfg.long_avg_weight) + 80'd32768;
			long_energy = 64'(blend >> 16);
		end
		clear_window();

		want.volume = 8'((vol_avg + 32'd128) >> 8);
		want.beat   = beat;
		want.bpm    = tempo_bpm;
		due_results.push_back(want);
		windows_closed++;
		if (beat) beats_flagged++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		avbt_pkg::out_item_t want;
		if (!arst_n) begin
			cfg.volume_smooth_weight = 8'd77;
			cfg.energy_ratio         = 10'd410;
			cfg.cooldown_ms          = 16'd200;
			cfg.long_avg_weight      = 16'd131;
			clear_window();
			vol_avg      = '0;
			long_energy  = '0;
			primed       = 0;
			last_beat_ms = '0;
			ring_pos     = '0;
			ring_fill    = '0;
			tempo_bpm    = '0;
			due_results.delete();
			failures       = 0;
			windows_closed = 0;
			beats_flagged  = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					avbt_pkg::REG_VOL_WEIGHT:   cfg.volume_smooth_weight = cfg_data[7:0];
					avbt_pkg::REG_ENERGY_RATIO: cfg.energy_ratio         = cfg_data[9:0];
					avbt_pkg::REG_COOLDOWN:     cfg.cooldown_ms          = cfg_data;
					avbt_pkg::REG_LONG_WEIGHT:  cfg.long_avg_weight      = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				take_sample(sample);
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					report("result with none expected", result, -1);
				end else begin
					want = due_results.pop_front();
					if (result.volume !== want.volume) report("volume", result.volume, want.volume);
					if (result.beat !== want.beat)     report("beat", result.beat, want.beat);
					if (result.bpm !== want.bpm)       report("bpm", result.bpm, want.bpm);
				end
			end
		end
		pending = due_results.size();
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the beat detector testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_MAX  = 512;
	localparam int HOLD_CYCLES = 3000;   // long receiver hold-off, fills the window queue
	localparam int SETTLE      = 250;    // beyond the worst back-end latency
	localparam int STALL_LIMIT = 20000;  // cycles with no item moving either way

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_wen = 0;
	logic [1:0] cfg_index = avbt_pkg::REG_VOL_WEIGHT;
	logic [15:0] cfg_data = '0;
	avbt_pkg::in_item_t  sample = '0;
	logic      push = 0;
	logic      full;
	avbt_pkg::out_item_t result;
	logic      empty;
	logic      pop = 0;

	int failures, pending, windows_closed, beats_flagged;

	// idling percentages, changed per phase by the stimulus
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	bit hold_req = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// stimulus-side view of the cooldown, used only to pick time steps
	int unsigned cur_cooldown = 200;
	logic [31:0] clock_ms = 32'd1000;

	always #6 clk = ~clk;

	audio_volume_beat_tempo_detector #(.WINDOW_MAX(WINDOW_MAX), .BEAT_HISTORY(8)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample(sample), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop)
	);

	avbt_checker #(.WINDOW_MAX(WINDOW_MAX), .BEAT_HISTORY(8)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample(sample), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.failures(failures), .pending(pending),
		.windows_closed(windows_closed), .beats_flagged(beats_flagged)
	);

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin
		static bit hold_done = 0;
		static int hold_left = 0;
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= arst_n && ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// Watchdog: gives up when nothing moves for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("audio_volume_beat_tempo_detector test failed");
			$finish;
		end
	end

	// One item; returns on the falling edge after it was taken.
	task automatic send(input logic [31:0] raw, input bit last, input logic [31:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 0;
			@(negedge clk);
		end
		sample.raw_word    = raw;
		sample.window_last = last;
		sample.now_ms      = ms;
		push = 1;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Sample word: one in ten is fully random; otherwise quiet ones stay near zero and
	// loud ones span the full range; the low 14 bits are junk the block must drop.
	function automatic logic [31:0] mic_word(input bit loud);
		int amp, s;
		if ($urandom_range(9) == 0)
			return $urandom;
		amp = loud ? 131071 : int'($urandom_range(0, 255));
		s = int'($urandom_range(0, 2 * amp)) - amp;
		return {s[17:0], 14'($urandom)};
	endfunction

	// A window of len items; the closing item carries clock_ms.
	// by_count leaves window_last low so the size limit closes it.
	task automatic send_window(input int len, input bit loud, input bit by_count = 1'b0);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send(mic_word(loud), !by_count, clock_ms);
			else
				send(mic_word(loud), 1'b0, $urandom);
		end
	endtask

	task automatic advance_ms();
		if (cur_cooldown <= 3)
			clock_ms += $urandom_range(0, 2);
		else if ($urandom_range(19) == 0)
			clock_ms += $urandom;
		else
			clock_ms += $urandom_range(0, 2 * cur_cooldown + 50);
	endtask

	// Sender pause: all results in, then long enough for any window still in flight.
	task automatic drain();
		push = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_wen   = 1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wen = 0;
	endtask

	task automatic configure(input logic [7:0] vw, input logic [9:0] ratio,
		input logic [15:0] cool, input logic [15:0] lw);
		drain();
		write_reg(avbt_pkg::REG_VOL_WEIGHT, 16'(vw));
		write_reg(avbt_pkg::REG_ENERGY_RATIO, 16'(ratio));
		write_reg(avbt_pkg::REG_COOLDOWN, cool);
		write_reg(avbt_pkg::REG_LONG_WEIGHT, lw);
		cur_cooldown = 32'(cool);
	endtask

	initial begin
		int phase_items;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed, reset register values. First window only seeds the average.
		send(32'h7FFF_FFFF, 1'b0, $urandom);
		send(32'h8000_0000, 1'b1, clock_ms);
		clock_ms += 300;
		send(32'h0000_0000, 1'b1, clock_ms);
		clock_ms += 300;
		send(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
		send(32'h0000_3FFF, 1'b1, clock_ms);
		// quiet then loud: beat, second beat gives the first tempo
		for (int k = 0; k < 2; k++) begin
			clock_ms += 300;
			send_window(2, 1'b0);
			clock_ms += 300;
			send_window(3, 1'b1);
		end
		// loud again inside the cooldown: no beat
		clock_ms += 50;
		send_window(3, 1'b1);
		// time stamp wraps through zero between beats
		clock_ms = 32'hFFFF_FF80;
		send_window(2, 1'b0);
		clock_ms += 32'd300;
		send_window(3, 1'b1);

		// Random phases with different registers and idling.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 51; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 51; end
				default: begin send_idle_pct = 28; pop_stall_pct = 28; end
			endcase
			case (ph)
				1: configure(8'd0, 10'd256, 16'd0, 16'd0);
				2: configure(8'd255, 10'd1023, 16'd65535, 16'd65535);
				3: configure(8'($urandom_range(255)), 10'($urandom_range(1023)),
					16'($urandom), 16'($urandom));
				default: configure(8'($urandom_range(255)), 10'($urandom_range(1023)),
					16'($urandom_range(0, 400)), 16'($urandom_range(0, 8000)));
			endcase
			phase_items = 0;
			if (ph == 5) begin
				// one window closed by the size limit alone
				advance_ms();
				send_window(WINDOW_MAX, 1'($urandom_range(1)), 1'b1);
				phase_items += WINDOW_MAX;
			end
			if (ph == 6) begin
				// receiver holds off while single-item windows pile up
				hold_req = 1;
				for (int k = 0; k < 16; k++) begin
					advance_ms();
					send_window(1, $urandom_range(3) == 0);
					phase_items++;
				end
				drain();
			end
			while (phase_items < 6) begin
				int len;
				len = int'($urandom_range(1, 3));
				advance_ms();
				send_window(len, $urandom_range(3) == 0);
				phase_items += len;
			end
		end
		push = 0;

		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d items in %0d windows, %0d beats predicted, over 9 register settings",
			items_sent, windows_closed, beats_flagged);
		$display("idling mixes: none, sender, receiver, both; one long receiver hold-off");
		if (failures == 0)
			$display("audio_volume_beat_tempo_detector test passed");
		else
			$display("audio_volume_beat_tempo_detector test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/avbt_pkg.sv
rtl/core/avbt_fifo.sv
rtl/core/avbt_front.sv
rtl/core/avbt_div.sv
rtl/core/avbt_back.sv
rtl/core/audio_volume_beat_tempo_detector.sv
verif/avbt_checker.sv
verif/testbench.sv
